### sv/ssh2d_pkg.sv
package ssh2d_pkg;

  typedef enum logic [3:0] {
    PH_LEN     = 4'b0001,
    PH_PADLEN  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_PADDING = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERR     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_NEG_LEN = 2'd1,
    ERR_PAD_FIT = 2'd2
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        first_of_payload;
    logic        last_of_payload;
    logic [7:0]  message_type;
    logic [30:0] payload_length;
    logic [31:0] sequence_number;
    err_e        error_code;
  } res_t;

endpackage

### sv/ssh2d_intf.sv
interface ssh2d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface ssh2d_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic        first_of_payload;
  logic        last_of_payload;
  logic [7:0]  message_type;
  logic [30:0] payload_length;
  logic [31:0] sequence_number;
  logic [1:0]  error_code;

  modport source (
    output valid, output kind, output payload_byte, output first_of_payload,
    output last_of_payload, output message_type, output payload_length,
    output sequence_number, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input first_of_payload,
    input last_of_payload, input message_type, input payload_length,
    input sequence_number, input error_code, output ready
  );
endinterface

### sv/ssh2d_in_stage.sv
module ssh2d_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssh2d_in_if.sink   in_i,
  input  logic       take_i,
  output logic       step_o,
  output logic [7:0] byte_o
);
  logic       valid_q;
  logic [7:0] data_q;
  logic       in_rdy;

  // word moves on when the result side can take whatever it produces
  assign step_o     = valid_q && take_i;
  assign in_rdy     = !valid_q || take_i;
  assign in_i.ready = in_rdy;
  assign byte_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_rdy) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      data_q <= in_i.data_byte;
    end
  end
endmodule

### sv/ssh2d_core.sv
module ssh2d_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output logic              res_vld_o,
  output ssh2d_pkg::res_t   res_o
);
  import ssh2d_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic [30:0] rem_q, rem_d;
  logic [7:0]  pad_q, pad_d;
  logic [1:0]  hdr_q, hdr_d;
  logic [7:0]  ptype_q, ptype_d;
  logic [31:0] seq_q, seq_d;
  logic        halted_q, halted_d;

  logic [31:0] acc_shift;
  logic [32:0] pad_diff;
  logic        first, last;
  logic        done, err;
  err_e        err_code;
  logic [7:0]  done_mt;
  logic [30:0] done_len;
  res_t        res;
  logic        res_vld;

  assign acc_shift = {acc_q[23:0], byte_i};
  assign pad_diff  = {1'b0, acc_q} - {25'd0, byte_i} - 33'd1;
  assign first     = (rem_q == acc_q[30:0]);
  assign last      = (rem_q <= 31'd1);

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    pad_d    = pad_q;
    hdr_d    = hdr_q;
    ptype_d  = ptype_q;
    seq_d    = seq_q;
    halted_d = halted_q;
    done     = 1'b0;
    err      = 1'b0;
    err_code = ERR_NONE;
    done_mt  = 8'd0;
    done_len = 31'd0;
    res      = '0;
    res_vld  = 1'b0;

    if (!halted_q) begin
      case (phase_q)
        PH_LEN: begin
          acc_d = acc_shift;
          if (hdr_q != 2'd3) begin
            hdr_d = hdr_q + 2'd1;
          end else begin
            hdr_d = 2'd0;
            if (acc_shift[31]) begin
              err      = 1'b1;
              err_code = ERR_NEG_LEN;
            end else if (acc_shift == 32'd0) begin
              err      = 1'b1;
              err_code = ERR_PAD_FIT;
            end else begin
              phase_d = PH_PADLEN;
            end
          end
        end
        PH_PADLEN: begin
          if (pad_diff[32]) begin
            err      = 1'b1;
            err_code = ERR_PAD_FIT;
          end else begin
            acc_d   = pad_diff[31:0];
            rem_d   = pad_diff[30:0];
            pad_d   = byte_i;
            ptype_d = 8'd0;
            if (pad_diff[31:0] != 32'd0) begin
              phase_d = PH_PAYLOAD;
            end else if (byte_i != 8'd0) begin
              phase_d = PH_PADDING;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          if (first) begin
            ptype_d = byte_i;
          end
          rem_d                = rem_q - 31'd1;
          res_vld              = 1'b1;
          res.kind             = KIND_PAYLOAD;
          res.payload_byte     = byte_i;
          res.first_of_payload = first;
          res.last_of_payload  = last;
          if (last) begin
            if (pad_q == 8'd0) begin
              done     = 1'b1;
              done_mt  = first ? byte_i : ptype_q;
              done_len = acc_q[30:0];
            end else begin
              phase_d = PH_PADDING;
            end
          end
        end
        PH_PADDING: begin
          pad_d = pad_q - 8'd1;
          if (pad_q <= 8'd1) begin
            done     = 1'b1;
            done_mt  = ptype_q;
            done_len = acc_q[30:0];
          end
        end
        default: begin
          phase_d = PH_LEN;
        end
      endcase
    end

    if (err) begin
      halted_d       = 1'b1;
      res_vld        = 1'b1;
      res.kind       = KIND_ERR;
      res.error_code = err_code;
    end

    // packet end: report and rearm for the next length header
    if (done) begin
      res_vld             = 1'b1;
      res.kind            = KIND_DONE;
      res.message_type    = done_mt;
      res.payload_length  = done_len;
      res.sequence_number = seq_q;
      seq_d               = seq_q + 32'd1;
      phase_d             = PH_LEN;
      acc_d               = 32'd0;
      hdr_d               = 2'd0;
      rem_d               = 31'd0;
      pad_d               = 8'd0;
    end
  end

  assign res_o     = res;
  assign res_vld_o = res_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN;
      acc_q    <= 32'd0;
      rem_q    <= 31'd0;
      pad_q    <= 8'd0;
      hdr_q    <= 2'd0;
      ptype_q  <= 8'd0;
      seq_q    <= 32'd0;
      halted_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      rem_q    <= rem_d;
      pad_q    <= pad_d;
      hdr_q    <= hdr_d;
      ptype_q  <= ptype_d;
      seq_q    <= seq_d;
      halted_q <= halted_d;
    end
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && err |=> halted_q)
    else $error("error word did not halt the deframer");

  a_done_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> phase_q == PH_LEN && hdr_q == 2'd0 && acc_q == 32'd0)
    else $error("packet end did not return to length header");

  a_seq_incr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> seq_q == $past(seq_q) + 32'd1)
    else $error("sequence number did not advance by one");

  a_payload_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != 31'd0)
    else $error("payload phase with no bytes remaining");
endmodule

### sv/ssh2d_out_stage.sv
module ssh2d_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             res_vld_i,
  input  ssh2d_pkg::res_t  res_i,
  output logic             take_o,
  ssh2d_out_if.source      out_o
);
  import ssh2d_pkg::*;

  logic valid_q;
  res_t res_q;

  assign take_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= step_i && res_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && step_i && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.kind             = res_q.kind;
  assign out_o.payload_byte     = res_q.payload_byte;
  assign out_o.first_of_payload = res_q.first_of_payload;
  assign out_o.last_of_payload  = res_q.last_of_payload;
  assign out_o.message_type     = res_q.message_type;
  assign out_o.payload_length   = res_q.payload_length;
  assign out_o.sequence_number  = res_q.sequence_number;
  assign out_o.error_code       = res_q.error_code;
endmodule

### sv/ssh2_packet_deframer.sv
// Throughput: one byte per cycle unless out_o.ready stalls the result register;
// the input register holds one byte, the result register one word, and the
// single state update path sets the pace.
// Reset (rst_ni, async, active low) clears the header state, the sequence
// counter and the halt flag; only reset clears a halt after an error.
module ssh2_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssh2d_in_if.sink    in_i,
  ssh2d_out_if.source out_o
);
  import ssh2d_pkg::*;

  logic       take;
  logic       step;
  logic [7:0] data;
  logic       res_vld;
  res_t       res;

  ssh2d_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .step_o (step),
    .byte_o (data)
  );

  ssh2d_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (data),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  ssh2d_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .res_vld_i (res_vld),
    .res_i     (res),
    .take_o    (take),
    .out_o     (out_o)
  );
endmodule

### verif/ssh2_packet_deframer_test.sv
module ssh2_packet_deframer_test;
  import ssh2d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // Tracks the deframer state and holds the words it should emit, oldest first.
  class ssh2_frame_tracker;
    phase_e      stage;
    logic [31:0] len_acc;
    logic [30:0] pay_left;
    logic [7:0]  pad_left;
    logic [1:0]  hdr_cnt;
    logic [7:0]  msg_type;
    logic [31:0] seq_cnt;
    bit          stopped;
    res_t        due_words[$];
    int unsigned words_seen;
    int unsigned packets_done;
    int unsigned mismatches;

    function new();
      stage = PH_LEN;
      len_acc = '0;
      pay_left = '0;
      pad_left = '0;
      hdr_cnt = '0;
      msg_type = '0;
      seq_cnt = '0;
      stopped = 1'b0;
      words_seen = 0;
      packets_done = 0;
      mismatches = 0;
    endfunction

    function void close_packet(inout res_t w);
      w.kind = KIND_DONE;
      w.message_type = msg_type;
      w.payload_length = len_acc[30:0];
      w.sequence_number = seq_cnt;
      seq_cnt = seq_cnt + 32'd1;
      packets_done++;
      stage = PH_LEN;
      len_acc = '0;
      hdr_cnt = '0;
      pay_left = '0;
      pad_left = '0;
    endfunction

    function void raise_error(inout res_t w, input err_e code);
      stopped = 1'b1;
      w.kind = KIND_ERR;
      w.error_code = code;
    endfunction

    function void take_byte(logic [7:0] b);
      res_t w;
      bit   give;
      bit   first;
      bit   last;
      w = '0;
      give = 1'b0;
      if (stopped) return;
      case (stage)
        PH_PADLEN: begin
          give = 1'b1;
          if ({24'd0, b} + 32'd1 > len_acc) begin
            raise_error(w, ERR_PAD_FIT);
          end else begin
            len_acc = len_acc - {24'd0, b} - 32'd1;
            pay_left = len_acc[30:0];
            pad_left = b;
            msg_type = '0;
            if (pay_left != 0) begin
              stage = PH_PAYLOAD;
              give = 1'b0;
            end else if (pad_left != 0) begin
              stage = PH_PADDING;
              give = 1'b0;
            end else begin
              close_packet(w);
            end
          end
        end
        PH_PAYLOAD: begin
          first = ({1'b0, pay_left} == len_acc);
          last = (pay_left <= 1);
          if (first) msg_type = b;
          if (pay_left != 0) pay_left = pay_left - 31'd1;
          w.payload_byte = b;
          w.first_of_payload = first;
          w.last_of_payload = last;
          give = 1'b1;
          // padding-free packet: the final payload byte rides on the done word
          if (last) begin
            if (pad_left == 0) close_packet(w);
            else stage = PH_PADDING;
          end
        end
        PH_PADDING: begin
          if (pad_left != 0) pad_left = pad_left - 8'd1;
          if (pad_left == 0) begin
            close_packet(w);
            give = 1'b1;
          end
        end
        default: begin
          len_acc = {len_acc[23:0], b};
          if (hdr_cnt < 3) begin
            hdr_cnt = hdr_cnt + 2'd1;
          end else begin
            hdr_cnt = '0;
            if (len_acc[31]) begin
              raise_error(w, ERR_NEG_LEN);
              give = 1'b1;
            end else if (len_acc == 0) begin
              raise_error(w, ERR_PAD_FIT);
              give = 1'b1;
            end else begin
              stage = PH_PADLEN;
            end
          end
        end
      endcase
      if (give) due_words.push_back(w);
    endfunction

    function void check_word(res_t got);
      res_t want;
      words_seen++;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("word %0d: unexpected, kind=%0d byte=%h", words_seen, got.kind,
                   got.payload_byte);
        return;
      end
      want = due_words.pop_front();
      if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
          got.first_of_payload !== want.first_of_payload ||
          got.last_of_payload !== want.last_of_payload ||
          got.message_type !== want.message_type ||
          got.payload_length !== want.payload_length ||
          got.sequence_number !== want.sequence_number ||
          got.error_code !== want.error_code) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display({"word %0d mismatch: exp kind=%0d byte=%h f=%b l=%b type=%h",
                    " len=%0d seq=%0d err=%0d"},
                   words_seen, want.kind, want.payload_byte, want.first_of_payload,
                   want.last_of_payload, want.message_type, want.payload_length,
                   want.sequence_number, want.error_code);
          $display("    got kind=%0d byte=%h f=%b l=%b type=%h len=%0d seq=%0d err=%0d",
                   got.kind, got.payload_byte, got.first_of_payload,
                   got.last_of_payload, got.message_type, got.payload_length,
                   got.sequence_number, got.error_code);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned cycle_cnt = 0;

  ssh2d_in_if  byte_if ();
  ssh2d_out_if word_if ();

  ssh2_packet_deframer dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (word_if)
  );

  ssh2_frame_tracker tracker;
  logic [7:0]        byte_stream[$];
  string             error_name;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // fill < 0 gives random payload and padding bytes
  task automatic add_packet(int pay_len, int pad_len, int fill);
    logic [31:0] plen;
    plen = pay_len + pad_len + 1;
    byte_stream.push_back(plen[31:24]);
    byte_stream.push_back(plen[23:16]);
    byte_stream.push_back(plen[15:8]);
    byte_stream.push_back(plen[7:0]);
    byte_stream.push_back(pad_len[7:0]);
    repeat (pay_len + pad_len)
      byte_stream.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
  endtask

  // one bad header at the very end; the block halts for the rest of the run
  task automatic add_bad_header();
    logic [31:0] plen;
    case ($urandom_range(0, 2))
      0: begin
        error_name = "negative length";
        plen = $urandom() | 32'h8000_0000;
        for (int i = 3; i >= 0; i--) byte_stream.push_back(plen[8*i +: 8]);
      end
      1: begin
        error_name = "zero length";
        repeat (4) byte_stream.push_back(8'h00);
      end
      default: begin
        error_name = "padding overrun";
        plen = $urandom_range(1, 20);
        for (int i = 3; i >= 0; i--) byte_stream.push_back(plen[8*i +: 8]);
        byte_stream.push_back(8'($urandom_range(plen, 255)));
      end
    endcase
    repeat (6) byte_stream.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_stream();
    int pkt_no;
    int pay_len;
    int pad_len;
    add_packet(0, 0, -1);
    add_packet(0, 2, 8'hFF);
    add_packet(1, 0, 8'hFF);
    add_packet(1, 1, 8'h00);
    pkt_no = 0;
    while (byte_stream.size() < 1340) begin
      if (pkt_no == 3) begin
        pay_len = $urandom_range(0, 8);
        pad_len = 255;
      end else if (pkt_no == 7) begin
        pay_len = $urandom_range(256, 300);
        pad_len = $urandom_range(0, 8);
      end else begin
        pay_len = ($urandom_range(0, 99) < 12) ? 0 : $urandom_range(1, 24);
        pad_len = ($urandom_range(0, 99) < 25) ? 0 : $urandom_range(1, 12);
      end
      add_packet(pay_len, pad_len, -1);
      pkt_no++;
    end
    add_bad_header();
  endtask

  task automatic feed_bytes();
    int next_idx;
    int sent;
    next_idx = 0;
    sent = 0;
    while (sent < byte_stream.size()) begin
      @(posedge clk_i);
      if (byte_if.valid && byte_if.ready) begin
        tracker.take_byte(byte_if.data_byte);
        sent++;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (next_idx < byte_stream.size() &&
            ((next_idx >= 800 && next_idx < 1000) || $urandom_range(0, 99) >= 32)) begin
          byte_if.valid <= 1'b1;
          byte_if.data_byte <= byte_stream[next_idx];
          next_idx++;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  endtask

  task automatic drain_words();
    res_t got;
    int   hold_left;
    bit   held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk_i);
      if (word_if.valid && word_if.ready) begin
        got.kind = kind_e'(word_if.kind);
        got.payload_byte = word_if.payload_byte;
        got.first_of_payload = word_if.first_of_payload;
        got.last_of_payload = word_if.last_of_payload;
        got.message_type = word_if.message_type;
        got.payload_length = word_if.payload_length;
        got.sequence_number = word_if.sequence_number;
        got.error_code = err_e'(word_if.error_code);
        tracker.check_word(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        word_if.ready <= 1'b0;
      end else if (!held_once && tracker.words_seen >= 150) begin
        // long back-pressure so the input side backs up
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        word_if.ready <= 1'b0;
      end else begin
        word_if.ready <= (tracker.words_seen >= 450 && tracker.words_seen < 650) ||
                         ($urandom_range(0, 99) >= 32);
      end
    end
  endtask

  initial begin
    byte_if.valid = 1'b0;
    byte_if.data_byte = 8'h00;
    word_if.ready = 1'b0;
    tracker = new();
    build_stream();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      drain_words();
    join_none
    feed_bytes();
    while (tracker.due_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d bytes, checked %0d words over %0d packets", byte_stream.size(),
             tracker.words_seen, tracker.packets_done);
    $display("stream ended on a %s header; %0d mismatches", error_name,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.due_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
